// ===== src/leb_pkg.sv =====
// line edit buffer package: sizes, opcodes and the controller/datapath interface types
// no dependencies
`default_nettype none

package leb_pkg;

  localparam int LINE_MAX = 128;
  localparam int CNT_W    = $clog2(LINE_MAX);
  localparam int POS_W    = 8;
  localparam int CH_W     = 8;
  localparam int OUT_W    = 7;
  localparam int COL_W    = 8;
  localparam int PRM_W    = 5;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [PRM_W-1:0] PROMPT_RESET = 5'd2;
  localparam logic             REG_PROMPT   = 1'b0;

  typedef enum logic [2:0] {
    OP_INSERT    = 3'd0,
    OP_BACKSPACE = 3'd1,
    OP_LEFT      = 3'd2,
    OP_RIGHT     = 3'd3,
    OP_SET       = 3'd4,
    OP_CLEAR     = 3'd5,
    OP_READ      = 3'd6
  } op_e;

  typedef struct packed {
    logic load;
    logic shift_init;
    logic shift_step;
    logic commit;
  } leb_cmd_t;

  typedef struct packed {
    logic do_shift;
    logic shift_last;
    logic out_free;
  } leb_status_t;

endpackage

`default_nettype wire

// ===== src/leb_ctrl.sv =====
// line edit buffer controller: sequences load, tail shift and commit of one word
// depends on leb_pkg
`default_nettype none

module leb_ctrl
  import leb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire leb_status_t status_i,
  output leb_cmd_t         cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_SHIFT = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_FINAL = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.do_shift) begin
          cmd_o.shift_init = 1'b1;
          state_d          = ST_SHIFT;
        end else begin
          state_d = ST_FINAL;
        end
      end
      ST_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (status_i.shift_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINAL;
      end
      ST_FINAL: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/leb_datapath.sv =====
// line edit buffer datapath: text store, fill and cursor counters, shift pipe, output register
// depends on leb_pkg
`default_nettype none

module leb_datapath
  import leb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire leb_cmd_t         cmd_i,
  output leb_status_t           status_o,
  input  wire logic [2:0]       op_i,
  input  wire logic [CH_W-1:0]  ch_i,
  input  wire logic [POS_W-1:0] position_i,
  input  wire logic [PRM_W-1:0] prompt_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  status_bit_o,
  output logic [OUT_W-1:0]      cursor_now_o,
  output logic [OUT_W-1:0]      length_now_o,
  output logic [CH_W-1:0]       char_out_o,
  output logic [COL_W-1:0]      column_o
);

  logic [CH_W-1:0]  mem [LINE_MAX];

  op_e              op_q;
  logic [CH_W-1:0]  ch_q;
  logic [POS_W-1:0] pos_q;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] cur_q, cur_d;
  logic [CNT_W-1:0] src_q;
  logic [CNT_W-1:0] wdst_q;
  logic             pend_q;
  logic [CH_W-1:0]  rdata_q;
  logic [CNT_W-1:0] rd_addr;
  logic             is_ins;
  logic             ins_ok;
  logic             bs_ok;
  logic             refused;
  logic [CH_W-1:0]  got;
  logic [COL_W:0]   col_sum;
  logic             out_valid_q;

  assign is_ins = (op_q == OP_INSERT);
  assign ins_ok = (fill_q != CNT_W'(LINE_MAX - 1));
  assign bs_ok  = (cur_q != '0);

  assign status_o.do_shift   = ((is_ins && ins_ok) || (op_q == OP_BACKSPACE && bs_ok))
                               && (fill_q != cur_q);
  assign status_o.shift_last = is_ins ? (src_q == cur_q) : (src_q == fill_q - CNT_W'(1));
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  // input word latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(op_i);
      ch_q  <= ch_i;
      pos_q <= position_i;
    end
  end

  // shift source walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_init) begin
      src_q <= is_ins ? fill_q - CNT_W'(1) : cur_q;
    end else if (cmd_i.shift_step) begin
      src_q <= is_ins ? src_q - CNT_W'(1) : src_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.shift_step;
    end
  end

  always_ff @(posedge clk_i) begin
    wdst_q <= is_ins ? src_q + CNT_W'(1) : src_q - CNT_W'(1);
  end

  // text store: one read and one write port
  assign rd_addr = cmd_i.shift_step ? src_q : pos_q[CNT_W-1:0];

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      mem[wdst_q] <= rdata_q;
    end else if (cmd_i.commit && is_ins && ins_ok) begin
      mem[cur_q] <= ch_q;
    end
  end

  // counter update at commit
  always_comb begin
    fill_d  = fill_q;
    cur_d   = cur_q;
    refused = 1'b0;
    got     = '0;
    case (op_q)
      OP_INSERT: begin
        if (ins_ok) begin
          fill_d = fill_q + CNT_W'(1);
          cur_d  = cur_q + CNT_W'(1);
        end else begin
          refused = 1'b1;
        end
      end
      OP_BACKSPACE: begin
        if (bs_ok) begin
          fill_d = fill_q - CNT_W'(1);
          cur_d  = cur_q - CNT_W'(1);
        end else begin
          refused = 1'b1;
        end
      end
      OP_LEFT: begin
        if (bs_ok) begin
          cur_d = cur_q - CNT_W'(1);
        end
      end
      OP_RIGHT: begin
        if (cur_q < fill_q) begin
          cur_d = cur_q + CNT_W'(1);
        end
      end
      OP_SET: begin
        cur_d = (pos_q > POS_W'(fill_q)) ? fill_q : pos_q[CNT_W-1:0];
      end
      OP_CLEAR: begin
        fill_d = '0;
        cur_d  = '0;
      end
      OP_READ: begin
        if (pos_q < POS_W'(fill_q)) begin
          got = rdata_q;
        end
      end
      default: begin
        fill_d = fill_q;
      end
    endcase
  end

  assign col_sum = (COL_W+1)'(cur_d) + (COL_W+1)'(prompt_i) + (COL_W+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cur_q  <= '0;
    end else if (cmd_i.commit) begin
      fill_q <= fill_d;
      cur_q  <= cur_d;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_bit_o <= refused;
      cursor_now_o <= OUT_W'(cur_d);
      length_now_o <= OUT_W'(fill_d);
      char_out_o   <= got;
      column_o     <= col_sum[COL_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;

  a_cursor_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= fill_q)
    else $error("cursor beyond fill count");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(LINE_MAX - 1))
    else $error("fill count beyond capacity");

  a_commit_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !pend_q)
    else $error("commit while a shift write is pending");

  a_commit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || !out_stall_i))
    else $error("commit overwrites an untaken word");

  a_shift_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_init |-> status_o.do_shift)
    else $error("shift started without a tail to move");

endmodule

`default_nettype wire

// ===== src/line_edit_buffer_core.sv =====
// line edit buffer top level: configuration port, controller and datapath
// depends on leb_pkg, leb_ctrl, leb_datapath
// an insert or backspace that moves a tail of n characters (n up to 126) runs a shift loop
// over the text store's one read and one write port before its result word is committed
// input: a new word is accepted only after the previous word's result has been committed
// reset: fill count and cursor clear to zero, prompt length to 2, store contents stay undefined
`default_nettype none

module line_edit_buffer_core
  import leb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         op_i,
  input  wire logic [CH_W-1:0]    ch_i,
  input  wire logic [POS_W-1:0]   position_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    status_o,
  output logic [OUT_W-1:0]        cursor_now_o,
  output logic [OUT_W-1:0]        length_now_o,
  output logic [CH_W-1:0]         char_out_o,
  output logic [COL_W-1:0]        column_o
);

  leb_cmd_t        cmd;
  leb_status_t     dp_status;
  logic [PRM_W-1:0] prompt_q;
  logic             reg_sel;

  // register file
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1] == REG_PROMPT);
  assign prdata  = reg_sel ? PDATA_W'(prompt_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prompt_q <= PROMPT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      prompt_q <= pwdata[PRM_W-1:0];
    end
  end

  leb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  leb_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .op_i         (op_i),
    .ch_i         (ch_i),
    .position_i   (position_i),
    .prompt_i     (prompt_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_bit_o (status_o),
    .cursor_now_o (cursor_now_o),
    .length_now_o (length_now_o),
    .char_out_o   (char_out_o),
    .column_o     (column_o)
  );

endmodule

`default_nettype wire

// ===== tb/line_edit_buffer_core_test.sv =====
// self-checking test of line_edit_buffer_core: edit words in, one checked result word out
// depends on leb_pkg and the line_edit_buffer_core rtl, nothing else
`default_nettype none

module line_edit_buffer_core_test
  import leb_pkg::*;
;

  localparam logic [2:0] OP_UNUSED   = 3'd7;
  localparam int         SETTLE      = 3 + LINE_MAX + 10;
  localparam int         QUIET_LIMIT = 4000;
  localparam int         HOLD_CYCLES = 400;

  typedef struct packed {
    logic             status;
    logic [OUT_W-1:0] cursor;
    logic [OUT_W-1:0] length;
    logic [CH_W-1:0]  chr;
    logic [COL_W-1:0] col;
  } edit_result_t;

  class line_edit_tracker;
    bit [CH_W-1:0]  text [LINE_MAX];
    int unsigned    fill = 0;
    int unsigned    cur = 0;
    bit [PRM_W-1:0] prompt = PROMPT_RESET;
    edit_result_t   pending_words [$];
    int             errors = 0;

    task report(string what, logic [7:0] got, logic [7:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    function void apply_edit(logic [2:0] op, logic [CH_W-1:0] ch, logic [POS_W-1:0] pos);
      edit_result_t res;
      int unsigned  i;
      res = '0;
      case (op)
        OP_INSERT: begin
          if (fill < LINE_MAX - 1) begin
            for (i = fill; i > cur; i--) text[i] = text[i-1];
            text[cur] = ch;
            fill++;
            cur++;
          end else begin
            res.status = 1'b1;
          end
        end
        OP_BACKSPACE: begin
          if (cur > 0) begin
            for (i = cur - 1; i + 1 < fill; i++) text[i] = text[i+1];
            fill--;
            cur--;
          end else begin
            res.status = 1'b1;
          end
        end
        OP_LEFT: begin
          if (cur > 0) cur--;
        end
        OP_RIGHT: begin
          if (cur < fill) cur++;
        end
        OP_SET: begin
          cur = (pos > fill) ? fill : pos;
        end
        OP_CLEAR: begin
          fill = 0;
          cur = 0;
        end
        OP_READ: begin
          if (pos < fill) res.chr = text[pos];
        end
        default: ;
      endcase
      res.cursor = OUT_W'(cur);
      res.length = OUT_W'(fill);
      res.col    = COL_W'(cur + prompt + 1);
      pending_words.push_back(res);
    endfunction

    task check_word(edit_result_t got);
      edit_result_t want;
      if (pending_words.size() == 0) begin
        report("unexpected word", 8'd1, 8'd0);
        return;
      end
      want = pending_words.pop_front();
      if (got.status !== want.status) report("status", 8'(got.status), 8'(want.status));
      if (got.cursor !== want.cursor) report("cursor_now", 8'(got.cursor), 8'(want.cursor));
      if (got.length !== want.length) report("length_now", 8'(got.length), 8'(want.length));
      if (got.chr !== want.chr) report("char_out", got.chr, want.chr);
      if (got.col !== want.col) report("column", got.col, want.col);
    endtask
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [2:0]         op_i        = '0;
  logic [CH_W-1:0]    ch_i        = '0;
  logic [POS_W-1:0]   position_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               status_o;
  logic [OUT_W-1:0]   cursor_now_o;
  logic [OUT_W-1:0]   length_now_o;
  logic [CH_W-1:0]    char_out_o;
  logic [COL_W-1:0]   column_o;

  line_edit_tracker sb;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;

  line_edit_buffer_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .ch_i         (ch_i),
    .position_i   (position_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .cursor_now_o (cursor_now_o),
    .length_now_o (length_now_o),
    .char_out_o   (char_out_o),
    .column_o     (column_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // receiver: random stall, or a long hold-off when requested
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_word('{status_o, cursor_now_o, length_now_o, char_out_o, column_o});
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("line_edit_buffer_core_test failed");
        $finish;
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_word(input logic [2:0] op, input logic [CH_W-1:0] ch,
                           input logic [POS_W-1:0] pos);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    ch_i       <= ch;
    position_i <= pos;
    do @(posedge clk_i); while (in_stall_o);
    sb.apply_edit(op, ch, pos);
    @(negedge clk_i);
  endtask

  task automatic edit_word(input int mood);
    int             r;
    int             ins;
    int             bsp;
    logic [2:0]     op;
    logic [POS_W-1:0] pos;
    r   = $urandom_range(99);
    ins = (mood == 0) ? 65 : (mood == 1) ? 15 : (mood == 3) ? 85 : 35;
    bsp = (mood == 1) ? 40 : (mood == 3) ? 3 : 12;
    if (r < ins) begin
      op = OP_INSERT;
    end else if (r < ins + bsp) begin
      op = OP_BACKSPACE;
    end else begin
      case ($urandom_range(15))
        0, 1, 2: op = OP_LEFT;
        3, 4, 5: op = OP_RIGHT;
        6, 7:    op = OP_SET;
        14:      op = (mood == 3) ? OP_READ : OP_CLEAR;
        15:      op = OP_UNUSED;
        default: op = OP_READ;
      endcase
    end
    if ($urandom_range(3) == 0) pos = POS_W'($urandom_range(255));
    else pos = POS_W'($urandom_range(sb.fill + 1));
    send_word(op, CH_W'($urandom_range(255)), pos);
  endtask

  task automatic run_random(input int count);
    int sent;
    int kind;
    int mood;
    sent = 0;
    while (sent < count) begin
      kind = (sent == 0) ? 0 : $urandom_range(9);
      if (kind == 0) begin
        // type until the line is full, then push against the limit
        while (sb.fill < LINE_MAX - 1) begin
          edit_word(3);
          sent++;
        end
        repeat (2) begin
          send_word(OP_INSERT, CH_W'($urandom_range(255)), POS_W'($urandom_range(255)));
          sent++;
        end
      end else if (kind == 9) begin
        repeat (8) begin
          send_word(3'($urandom_range(7)), CH_W'($urandom_range(255)),
                    POS_W'($urandom_range(255)));
          sent++;
        end
      end else begin
        mood = $urandom_range(2);
        repeat (16) begin
          edit_word(mood);
          sent++;
        end
      end
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] data,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'(4 * int'(REG_PROMPT));
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_prompt(input logic [PRM_W-1:0] value);
    logic [PDATA_W-1:0] rdata;
    apb_access(1'b1, PDATA_W'(value), rdata);
    sb.prompt = value;
    apb_access(1'b0, '0, rdata);
    if (rdata[PRM_W-1:0] !== value) begin
      sb.report("prompt readback", 8'(rdata[PRM_W-1:0]), 8'(value));
    end
  endtask

  initial begin
    int             p;
    logic [PRM_W-1:0] prompt_plan [4];
    int             send_plan [4];
    int             stall_plan [4];
    sb = new();
    prompt_plan = '{5'd31, 5'd0, PRM_W'($urandom_range(1, 30)), PROMPT_RESET};
    send_plan   = '{0, 51, 0, 29};
    stall_plan  = '{0, 0, 51, 29};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed pass on an empty line with the reset prompt
    send_word(OP_BACKSPACE, 8'h00, 8'h00);
    send_word(OP_LEFT, 8'h00, 8'h00);
    send_word(OP_RIGHT, 8'h00, 8'h00);
    send_word(OP_READ, 8'h00, 8'h00);
    send_word(OP_SET, 8'h00, 8'hff);
    send_word(OP_UNUSED, 8'hff, 8'hff);
    send_word(OP_INSERT, 8'h00, 8'h00);
    send_word(OP_INSERT, 8'hff, 8'hff);
    send_word(OP_INSERT, 8'ha5, 8'h00);
    send_word(OP_LEFT, 8'h00, 8'h00);
    send_word(OP_INSERT, 8'h5a, 8'h00);
    send_word(OP_READ, 8'h00, 8'h00);
    send_word(OP_READ, 8'h00, 8'h01);
    send_word(OP_READ, 8'h00, 8'h02);
    send_word(OP_READ, 8'h00, 8'h03);
    send_word(OP_READ, 8'h00, 8'h04);
    send_word(OP_READ, 8'h00, 8'hff);
    send_word(OP_SET, 8'h00, 8'h01);
    send_word(OP_BACKSPACE, 8'h00, 8'h00);
    send_word(OP_SET, 8'h00, 8'hc8);
    send_word(OP_RIGHT, 8'h00, 8'h00);
    send_word(OP_CLEAR, 8'h00, 8'h00);
    send_word(OP_READ, 8'h00, 8'h00);
    send_word(OP_RIGHT, 8'h00, 8'h00);

    for (p = 0; p < 4; p++) begin
      drain_results();
      set_prompt(prompt_plan[p]);
      send_idle_pct = send_plan[p];
      stall_pct     = stall_plan[p];
      run_random(290);
    end

    // receiver holds off while words keep coming, so the input backs up
    drain_results();
    send_idle_pct = 0;
    stall_pct     = 29;
    hold_left     = HOLD_CYCLES;
    repeat (60) edit_word(2);

    drain_results();
    if (sb.errors == 0) begin
      $display("line_edit_buffer_core_test passed");
    end else begin
      $display("line_edit_buffer_core_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
